// ----- sv/txdma_pkg.sv -----
// shared constants and codes for the transmit ring dma chunk scheduler
// no dependencies
package txdma_pkg;

  // ring geometry
  localparam int RING_DEPTH = 256;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEN_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = LEN_W + 1;

  // fixed field widths of the channels
  localparam int OP_W     = 2;
  localparam int DATA_W   = 8;
  localparam int FIDX_W   = 8;
  localparam int STATUS_W = 2;
  localparam int START_W  = 8;
  localparam int TLEN_W   = 9;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_DONE  = 2'd1,
    OP_FETCH = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

endpackage

// ----- sv/tx_ring_dma_chunk_scheduler.sv -----
// transmit ring buffer with dma chunk issue, one module
// depends on txdma_pkg (constants, operation and status codes)

// Each beat on the input channel is a put, a transfer-done event or a fetch,
// and yields exactly one result beat. Puts and completions are resolved from
// the pointer registers in the accept cycle; a fetch reads the byte store, a
// synchronous memory whose registered read data feeds out_read_data; each
// result is valid in the cycle after its beat is accepted, and a new beat is
// taken every cycle while the result register is empty or being drained. The
// store is not cleared after reset; unwritten slots fetch an undefined byte.
module tx_ring_dma_chunk_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [txdma_pkg::OP_W-1:0]     in_operation,
  input  logic [txdma_pkg::DATA_W-1:0]   in_data_byte,
  input  logic [txdma_pkg::FIDX_W-1:0]   in_fetch_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [txdma_pkg::STATUS_W-1:0] out_status,
  output logic                          out_issue_transfer,
  output logic [txdma_pkg::START_W-1:0]  out_transfer_start,
  output logic [txdma_pkg::TLEN_W-1:0]   out_transfer_length,
  output logic [txdma_pkg::DATA_W-1:0]   out_read_data
);
  import txdma_pkg::*;

  // pointer state
  logic [IDX_W-1:0] wr_idx_r,      wr_idx_nxt;
  logic [IDX_W-1:0] chunk_start_r, chunk_start_nxt;
  logic [LEN_W-1:0] chunk_len_r,   chunk_len_nxt;
  logic             ring_idle_r,   ring_idle_nxt;

  // result register
  logic                out_valid_r,  out_valid_nxt;
  status_t             status_r,     status_nxt;
  logic                issue_r,      issue_nxt;
  logic [IDX_W-1:0]    tstart_r,     tstart_nxt;
  logic [LEN_W-1:0]    tlen_r,       tlen_nxt;
  logic                rd_sel_r,     rd_sel_nxt;

  // byte store
  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  rd_addr;

  logic             in_fire;
  op_t              op;
  logic [IDX_W-1:0] wr_next_slot;
  logic [SUM_W-1:0] chunk_end_sum;
  logic [IDX_W-1:0] chunk_end;
  logic             fetch_in_range;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign op       = op_t'(in_operation);
  assign rd_addr  = IDX_W'(in_fetch_index);

  // write index advance with wrap
  assign wr_next_slot = (32'(wr_idx_r) + 32'd1 >= 32'(RING_DEPTH)) ? '0 : wr_idx_r + 1'b1;

  // end of the chunk in flight, wrapping at the buffer end
  assign chunk_end_sum = SUM_W'(chunk_start_r) + SUM_W'(chunk_len_r);
  assign chunk_end     = (32'(chunk_end_sum) >= 32'(RING_DEPTH)) ? '0
                                                                 : IDX_W'(chunk_end_sum);

  assign fetch_in_range = 32'(in_fetch_index) < 32'(RING_DEPTH);

  // operation decode and next state
  always_comb begin
    wr_idx_nxt      = wr_idx_r;
    chunk_start_nxt = chunk_start_r;
    chunk_len_nxt   = chunk_len_r;
    ring_idle_nxt   = ring_idle_r;
    status_nxt      = ST_OK;
    issue_nxt       = 1'b0;
    tstart_nxt      = '0;
    tlen_nxt        = '0;
    rd_sel_nxt      = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    if (in_fire) begin
      unique case (op)
        OP_PUT: begin
          if (ring_idle_r) begin
            // idle ring: store and send this single byte at once
            mem_we          = 1'b1;
            chunk_start_nxt = wr_idx_r;
            chunk_len_nxt   = LEN_W'(1);
            ring_idle_nxt   = 1'b0;
            wr_idx_nxt      = wr_next_slot;
            issue_nxt       = 1'b1;
            tstart_nxt      = wr_idx_r;
            tlen_nxt        = LEN_W'(1);
          end else if (wr_idx_r == chunk_start_r) begin
            status_nxt = ST_FULL;
          end else begin
            mem_we     = 1'b1;
            wr_idx_nxt = wr_next_slot;
          end
        end
        OP_DONE: begin
          if (ring_idle_r) begin
            status_nxt = ST_IGNORED;
          end else if (chunk_end == wr_idx_r) begin
            ring_idle_nxt = 1'b1;
          end else begin
            // next chunk runs to the write index or to the buffer end
            chunk_start_nxt = chunk_end;
            if (wr_idx_r > chunk_end) begin
              chunk_len_nxt = LEN_W'(wr_idx_r) - LEN_W'(chunk_end);
            end else begin
              chunk_len_nxt = LEN_W'(RING_DEPTH) - LEN_W'(chunk_end);
            end
            issue_nxt  = 1'b1;
            tstart_nxt = chunk_end;
            tlen_nxt   = chunk_len_nxt;
          end
        end
        OP_FETCH: begin
          mem_re     = fetch_in_range;
          rd_sel_nxt = fetch_in_range;
        end
        default: begin
        end
      endcase
    end
    out_valid_nxt = in_fire || (out_valid_r && !out_ready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r      <= '0;
      chunk_start_r <= '0;
      chunk_len_r   <= '0;
      ring_idle_r   <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      wr_idx_r      <= wr_idx_nxt;
      chunk_start_r <= chunk_start_nxt;
      chunk_len_r   <= chunk_len_nxt;
      ring_idle_r   <= ring_idle_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload, loaded per accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      issue_r  <= issue_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
  end

  // byte store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_idx_r] <= in_data_byte;
    end
  end

  // byte store read port, registered data
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // output beat
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_issue_transfer  = issue_r;
  assign out_transfer_start  = START_W'(tstart_r);
  assign out_transfer_length = TLEN_W'(tlen_r);
  assign out_read_data       = rd_sel_r ? rd_data_r : '0;

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the transmit ring dma chunk scheduler: put, completion,
// fetch and unused-code beats are checked against a cycle-free shadow of the ring state
// depends on txdma_pkg and tx_ring_dma_chunk_scheduler
module tb_top;
  import txdma_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    status_t             status;
    logic                issue;
    logic [START_W-1:0]  start;
    logic [TLEN_W-1:0]   length;
    logic [DATA_W-1:0]   rdata;
  } tx_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = '0;
  logic [DATA_W-1:0]    in_data_byte = '0;
  logic [FIDX_W-1:0]    in_fetch_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_issue_transfer;
  logic [START_W-1:0]   out_transfer_start;
  logic [TLEN_W-1:0]    out_transfer_length;
  logic [DATA_W-1:0]    out_read_data;

  // shadow of the ring state, advanced at every accepted input beat
  logic [DATA_W-1:0]    shadow_bytes [RING_DEPTH];
  bit                   shadow_written [RING_DEPTH];
  int                   written_count = 0;
  logic [IDX_W-1:0]     wr_slot = '0;
  logic [IDX_W-1:0]     chunk_first = '0;
  logic [LEN_W-1:0]     chunk_bytes = '0;
  bit                   ring_idle_q = 1'b1;

  tx_result_t           pending_results[$];
  tx_result_t           head_result;
  int                   fail_count = 0;
  bit                   sender_idling = 1'b1;
  bit                   receiver_idling = 1'b1;
  int                   stall_left = 0;

  tx_ring_dma_chunk_scheduler DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_data_byte        (in_data_byte),
    .in_fetch_index      (in_fetch_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_issue_transfer  (out_issue_transfer),
    .out_transfer_start  (out_transfer_start),
    .out_transfer_length (out_transfer_length),
    .out_read_data       (out_read_data)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expected result of one beat; updates the shadow state
  function automatic tx_result_t ring_predict(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
                                              logic [FIDX_W-1:0] fidx);
    tx_result_t r;
    int         next_end;
    int         span;
    r = '0;
    case (op)
      OP_PUT: begin
        if (!ring_idle_q && wr_slot == chunk_first) begin
          // ring full, nothing stored
          r.status = ST_FULL;
        end else begin
          // idle ring sends the new byte at once
          if (ring_idle_q) begin
            chunk_first = wr_slot;
            chunk_bytes = LEN_W'(1);
            ring_idle_q = 1'b0;
            r.issue     = 1'b1;
            r.start     = wr_slot;
            r.length    = TLEN_W'(1);
          end
          shadow_bytes[wr_slot] = data;
          if (!shadow_written[wr_slot]) written_count++;
          shadow_written[wr_slot] = 1'b1;
          wr_slot = (int'(wr_slot) == RING_DEPTH - 1) ? '0 : wr_slot + 1'b1;
        end
      end
      OP_DONE: begin
        if (ring_idle_q) begin
          r.status = ST_IGNORED;
        end else begin
          next_end = int'(chunk_first) + int'(chunk_bytes);
          if (next_end >= RING_DEPTH) next_end = 0;
          if (next_end == int'(wr_slot)) begin
            ring_idle_q = 1'b1;
          end else begin
            // next chunk stops at the write slot or at the buffer end
            span = (int'(wr_slot) > next_end) ? int'(wr_slot) - next_end
                                              : RING_DEPTH - next_end;
            chunk_first = next_end[IDX_W-1:0];
            chunk_bytes = span[LEN_W-1:0];
            r.issue     = 1'b1;
            r.start     = next_end[START_W-1:0];
            r.length    = span[TLEN_W-1:0];
          end
        end
      end
      OP_FETCH: begin
        if (int'(fidx) < RING_DEPTH) r.rdata = shadow_bytes[fidx];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic bit ring_full();
    return !ring_idle_q && wr_slot == chunk_first;
  endfunction

  // random slot that has been written at least once
  function automatic logic [FIDX_W-1:0] pick_written_slot();
    int slot;
    slot = $urandom_range(0, RING_DEPTH - 1);
    while (!shadow_written[slot]) slot = (slot + 1) % RING_DEPTH;
    return slot[FIDX_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] rand_byte();
    return DATA_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [FIDX_W-1:0] rand_slot();
    return FIDX_W'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(string name, logic [TLEN_W-1:0] want,
                                      logic [TLEN_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // drive one input beat; called and returns at a falling edge
  task automatic send_beat(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
                           logic [FIDX_W-1:0] fidx);
    if (sender_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_data_byte   <= data;
    in_fetch_index <= fidx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(ring_predict(op, data, fidx));
    @(negedge clk);
  endtask

  // hold the sender until every outstanding result has come back
  task automatic wait_ring_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_beat(int done_pct, int fetch_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      send_beat(OP_UNUSED, rand_byte(), rand_slot());
    else if (roll < 3 + done_pct)
      send_beat(OP_DONE, rand_byte(), rand_slot());
    else if (roll < 3 + done_pct + fetch_pct && written_count != 0)
      send_beat(OP_FETCH, rand_byte(), pick_written_slot());
    else
      send_beat(OP_PUT, rand_byte(), rand_slot());
  endtask

  // unused code, completion while idle, idle put, chunk issue, fetch, return to idle
  task automatic test_directed_ops();
    send_beat(OP_UNUSED, 8'hff, 8'hff);
    send_beat(OP_DONE, 8'h00, 8'h00);
    send_beat(OP_PUT, 8'h00, 8'hff);
    send_beat(OP_PUT, 8'hff, 8'h00);
    send_beat(OP_PUT, 8'ha5, 8'h00);
    send_beat(OP_DONE, 8'h00, 8'h00);
    send_beat(OP_FETCH, 8'hff, 8'd0);
    send_beat(OP_FETCH, 8'h00, 8'd1);
    send_beat(OP_FETCH, 8'h00, 8'd2);
    send_beat(OP_DONE, 8'h00, 8'h00);
    send_beat(OP_DONE, 8'hff, 8'hff);
    send_beat(OP_PUT, 8'h5a, 8'h00);
    send_beat(OP_DONE, 8'h00, 8'h00);
    send_beat(OP_UNUSED, 8'h00, 8'h00);
  endtask

  // fill the whole ring, hit the full case, then drain through the buffer-end wrap
  task automatic test_fill_and_wrap();
    wait_ring_drained();
    while (!ring_full()) send_beat(OP_PUT, rand_byte(), rand_slot());
    send_beat(OP_PUT, rand_byte(), 8'h00);
    send_beat(OP_PUT, rand_byte(), 8'hff);
    send_beat(OP_FETCH, 8'h00, 8'hff);
    send_beat(OP_FETCH, 8'hff, 8'h00);
    send_beat(OP_FETCH, 8'h00, pick_written_slot());
    while (!ring_idle_q) send_beat(OP_DONE, rand_byte(), rand_slot());
    send_beat(OP_DONE, 8'h00, 8'h00);
  endtask

  // random traffic in segments that lean toward filling, mixing or draining
  task automatic test_random_mix(int count);
    int done_pct;
    int fetch_pct;
    done_pct  = 30;
    fetch_pct = 20;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            done_pct  = 5;
            fetch_pct = 8;
          end
          1: begin
            done_pct  = 30;
            fetch_pct = 20;
          end
          2: begin
            done_pct  = 60;
            fetch_pct = 15;
          end
          default: begin
            wait_ring_drained();
            done_pct  = 20;
            fetch_pct = 30;
          end
        endcase
      end
      send_random_beat(done_pct, fetch_pct);
    end
  endtask

  // back-to-back beats with the receiver always ready
  task automatic test_steady_stream(int count);
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    for (int i = 0; i < count; i++) send_random_beat(25, 20);
  endtask

  // receiver stalls in bursts of random length
  always @(negedge clk) begin
    if (!rst_n || !receiver_idling) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result beat with no expectation waiting");
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", TLEN_W'(head_result.status), TLEN_W'(out_status));
        check_field("issue_transfer", TLEN_W'(head_result.issue),
                    TLEN_W'(out_issue_transfer));
        check_field("transfer_start", TLEN_W'(head_result.start),
                    TLEN_W'(out_transfer_start));
        check_field("transfer_length", head_result.length, out_transfer_length);
        check_field("read_data", TLEN_W'(head_result.rdata), TLEN_W'(out_read_data));
      end
    end
  end

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_fill_and_wrap();
    test_random_mix(870);
    test_steady_stream(200);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** tx_ring_dma_chunk_scheduler: PASSED **");
    end else begin
      $display("** tx_ring_dma_chunk_scheduler: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #(4 * TIMEOUT_CYCLES);
    $display("** tx_ring_dma_chunk_scheduler: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
sv/txdma_pkg.sv
sv/tx_ring_dma_chunk_scheduler.sv
tb/sv/tb_top.sv
